>>> rtl/mbps_pkg.sv
// types and constants shared by the masked byte pattern search block
// no dependencies
package mbps_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned PATTERN_W    = 64;
  localparam int unsigned MASK_W       = 16;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned OFFSET_OUT_W = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_WILDCARD_MASK  = 2'd2,
    CFG_PATTERN_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_low;
    logic [PATTERN_W-1:0] pattern_high;
    logic [MASK_W-1:0]    wildcard_mask;
    logic [LEN_W-1:0]     pattern_length;
  } cfg_t;

  typedef struct packed {
    logic                    found;
    logic [OFFSET_OUT_W-1:0] match_offset;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

endpackage

>>> rtl/mbps_front.sv
// front end: accepts region bytes, keeps the byte window and counter,
// compares the pattern and emits at most one result per region
// depends on mbps_pkg
module mbps_front #(
  parameter int unsigned MAX_PATTERN_LEN = 16,
  parameter int unsigned OFFSET_BITS     = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbps_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mbps_pkg::DATA_W-1:0]  in_byte_i,
  input  logic                         in_last_i,
  input  logic                         queue_full_i,
  output mbps_pkg::push_t              push_o
);
  import mbps_pkg::*;

  localparam int unsigned IDX_W  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned WIDE_W = (OFFSET_BITS > OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;

  logic [DATA_W-1:0]      win_q [MAX_PATTERN_LEN];
  logic [DATA_W-1:0]      win_d [MAX_PATTERN_LEN];
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d, cnt_inc, diff;
  logic                   rep_q, rep_d;
  logic [LEN_W-1:0]       eff_len;
  logic [2*PATTERN_W-1:0] pat;
  logic                   accept, enough, match, hit;
  logic [WIDE_W-1:0]      off_wide;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign pat        = {cfg_i.pattern_high, cfg_i.pattern_low};

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_i.pattern_length > LEN_W'(MAX_PATTERN_LEN)) begin
      eff_len = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      eff_len = cfg_i.pattern_length;
    end
  end

  // shifted window, entry 0 newest
  always_comb begin
    win_d[0] = in_byte_i;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + OFFSET_BITS'(1);
  assign enough  = cnt_inc >= OFFSET_BITS'(eff_len);
  assign diff    = cnt_inc - OFFSET_BITS'(eff_len);
  assign off_wide = WIDE_W'(diff);

  // pattern byte j lines up with the byte received len-1-j words ago
  always_comb begin
    logic [LEN_W-1:0] idx;
    match = 1'b1;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      idx = eff_len - LEN_W'(j) - LEN_W'(1);
      if ((LEN_W'(j) < eff_len) && !cfg_i.wildcard_mask[j]) begin
        if (win_d[idx[IDX_W-1:0]] != pat[j*DATA_W +: DATA_W]) begin
          match = 1'b0;
        end
      end
    end
  end

  assign hit = ~rep_q & enough & match;

  always_comb begin
    push_o.push             = accept & ~rep_q & (hit | in_last_i);
    push_o.res.found        = hit;
    push_o.res.match_offset = hit ? off_wide[OFFSET_OUT_W-1:0] : '0;
    cnt_d = cnt_q;
    rep_d = rep_q;
    if (accept) begin
      if (in_last_i) begin
        cnt_d = '0;
        rep_d = 1'b0;
      end else begin
        cnt_d = cnt_inc;
        rep_d = rep_q | hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rep_q <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> accept)
    else $error("result pushed without an accepted word");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push && !in_last_i) |=> rep_q)
    else $error("region not marked reported after a mid-region result");

  a_no_result_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> !push_o.push)
    else $error("second result in one region");

endmodule

>>> rtl/mbps_queue.sv
// short result queue between the front end and the output stage
// depends on mbps_pkg
module mbps_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbps_pkg::push_t    push_i,
  output logic               full_o,
  output logic               valid_o,
  output mbps_pkg::result_t  data_o,
  input  logic               pop_i
);
  import mbps_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i.push & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.res;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> !full_o)
    else $error("push into full result queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty result queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue count out of range");

endmodule

>>> rtl/mbps_back.sv
// output stage: drains the result queue into a registered master port
// depends on mbps_pkg
module mbps_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  mbps_pkg::result_t                  q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mbps_pkg::OFFSET_OUT_W-1:0]  out_offset_o,
  output logic                               out_found_o
);
  import mbps_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign q_pop_o     = q_valid_i & (~valid_q | out_ready_i);
  assign valid_d     = q_pop_o | (valid_q & ~out_ready_i);
  assign out_valid_o = valid_q;
  assign out_offset_o = res_q.match_offset;
  assign out_found_o  = res_q.found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_data_i;
    end
  end

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> valid_q)
    else $error("popped result not presented");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> valid_q)
    else $error("result word dropped while output stalled");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.found) |-> (res_q.match_offset == '0))
    else $error("not-found result carries an offset");

endmodule

>>> rtl/masked_byte_pattern_search_top.sv
// masked byte pattern search, top level: config registers, front end,
// result queue and output stage; depends on mbps_pkg, mbps_front, mbps_queue, mbps_back
// throughput one byte per cycle; the result for the byte that completes the match
// or ends the region passes the result queue and output register to the master port;
// tready drops only when the two-entry result queue is full behind a stalled output
// async active-low reset clears the counter, report flag, queue and output valid
module masked_byte_pattern_search_top #(
  parameter int unsigned MAX_PATTERN_LEN = 16,
  parameter int unsigned OFFSET_BITS     = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [7:0]                           s_axis_tdata_i,  // [7:0] data_byte
  input  logic                                 s_axis_tlast_i,  // last_byte
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [31:0]                          m_axis_tdata_o,  // [31:0] match_offset
  output logic                                 m_axis_tuser_o   // [0] found
);
  import mbps_pkg::*;

  cfg_t    cfg_q;
  push_t   push;
  logic    q_full, q_valid, q_pop;
  result_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.wildcard_mask  <= '0;
      cfg_q.pattern_length <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_wdata_i[PATTERN_W-1:0];
        CFG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_wdata_i[PATTERN_W-1:0];
        CFG_WILDCARD_MASK:  cfg_q.wildcard_mask  <= cfg_wdata_i[MASK_W-1:0];
        CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_wdata_i[LEN_W-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  mbps_front #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i[DATA_W-1:0]),
    .in_last_i    (s_axis_tlast_i),
    .queue_full_i (q_full),
    .push_o       (push)
  );

  mbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  mbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_offset_o (m_axis_tdata_o),
    .out_found_o  (m_axis_tuser_o)
  );

endmodule
